@@ rtl/tcld_pkg.sv @@
// Shared types and constants for the text cursor line discipline unit.
// No dependencies; tcld_rem and the top module refer to it by scoped names.
package tcld_pkg;

    // Character codes that the discipline treats specially.
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    // Result status codes.
    localparam logic [1:0] ST_CONTROL  = 2'd0;
    localparam logic [1:0] ST_GLYPH    = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;
    localparam logic [1:0] ST_LOADED   = 2'd3;

    // Item kinds.
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_GLYPH_HEIGHT  = 3'd2;
    localparam logic [2:0] REG_MONO_WIDTH    = 3'd3;
    localparam logic [2:0] REG_PROPORTIONAL  = 3'd4;

    // Configuration reset values.
    localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd396;
    localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd224;
    localparam logic [7:0]  RST_GLYPH_HEIGHT  = 8'd8;
    localparam logic [7:0]  RST_MONO_WIDTH    = 8'd6;
    localparam logic        RST_PROPORTIONAL  = 1'b0;

    // Status of the iterative remainder unit.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ rtl/tcld_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module tcld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 95
) (
    input  logic                                        clk,
    input  logic                                        en,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                            wdata,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else if (en)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

@@ rtl/tcld_rem.sv @@
// Restoring remainder unit, one dividend bit per cycle.
// Depends on tcld_pkg for its status struct.
module tcld_rem #(
    parameter int DW = 12,
    parameter int VW = 11
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [DW-1:0]           dividend,
    input  logic [VW-1:0]           divisor,
    output tcld_pkg::div_status_t   stat,
    output logic [VW-1:0]           remainder
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] dvd_reg, dvd_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW:0]   trial;
    logic [VW:0]   diff;

    assign trial = {rem_reg, dvd_reg[DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so it fits in VW bits.
            rem_next = (trial >= {1'b0, dvs_reg}) ? diff[VW-1:0] : trial[VW-1:0];
            dvd_next = {dvd_reg[DW-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/text_cursor_line_discipline_unit.sv @@
// Text cursor line discipline: one item in, one result item out, one item in work at a time.
// An item is accepted in IDLE and its result is registered in COMMIT; a tab with a nonzero stop
// first passes DIVIDE: 12 bit-serial remainder steps (one column bit a cycle), then a hand-over.
// A new item is taken only once the last one has committed; a stalled result holds the commit.
// Reset: cursor at column 0, row 0, registers at their defaults; the width table is
// not cleared and holds nothing defined until each entry is loaded.
module text_cursor_line_discipline_unit #(
    parameter int GLYPH_COUNT = 95,
    parameter int TAB_GLYPHS  = 4
) (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write port.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,

    // Input channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  char_byte,
    input  logic [6:0]  table_index,
    input  logic [7:0]  table_width,

    // Output channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [11:0] draw_x,
    output logic [11:0] draw_y,
    output logic [6:0]  glyph_code,
    output logic [7:0]  glyph_width,
    output logic        scroll_request
);

    // A tab stop is TAB_GLYPHS mono widths; these widths hold it and the tab target.
    localparam int STOP_W = 8 + $clog2(TAB_GLYPHS + 1);
    localparam int TGT_W  = ((STOP_W > 12) ? STOP_W : 12) + 1;
    localparam int AW     = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DIVIDE = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    // Configuration registers.
    logic [11:0] sw_reg;
    logic [11:0] sh_reg;
    logic [7:0]  gh_reg;
    logic [7:0]  mw_reg;
    logic        prop_reg;

    // Cursor, captured item and control.
    state_t      state_reg, state_next;
    logic [11:0] col_reg, col_next;
    logic [11:0] row_reg, row_next;
    logic        kind_reg;
    logic [7:0]  ch_reg;

    // Output register; it holds a result while the next item is taken in.
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  status_reg, status_next;
    logic [11:0] dx_reg, dx_next;
    logic [11:0] dy_reg, dy_next;
    logic [6:0]  gi_reg, gi_next;
    logic [7:0]  gw_reg, gw_next;
    logic        scroll_reg, scroll_next;

    logic                  accept;
    logic                  commit_go;
    logic [STOP_W-1:0]     stop;
    logic                  stop_zero;
    logic [6:0]            in_gi;
    logic                  in_printable;
    logic                  in_gi_ok;
    logic                  in_ti_ok;
    logic                  is_tab_in;

    logic                  ram_en;
    logic                  ram_we;
    logic [AW-1:0]         ram_addr;
    logic [7:0]            ram_rdata;

    logic                  div_start;
    tcld_pkg::div_status_t div_stat;
    logic [STOP_W-1:0]     div_rem;

    logic [6:0]            gi_c;
    logic                  gi_ok_c;
    logic [7:0]            gw_c;
    logic [12:0]           glyph_sum;
    logic [12:0]           lf_sum;
    logic                  lf_ok;
    logic [11:0]           lf_row;
    logic [TGT_W-1:0]      tab_target;
    logic [TGT_W-1:0]      tab_final;
    logic                  tab_wrap;
    logic [11:0]           glyph_col;

    // ------------------------------------------------------------------
    // Configuration. Writes must only arrive while the block is idle; the block itself does not enforce this.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg   <= tcld_pkg::RST_SCREEN_WIDTH;
            sh_reg   <= tcld_pkg::RST_SCREEN_HEIGHT;
            gh_reg   <= tcld_pkg::RST_GLYPH_HEIGHT;
            mw_reg   <= tcld_pkg::RST_MONO_WIDTH;
            prop_reg <= tcld_pkg::RST_PROPORTIONAL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tcld_pkg::REG_SCREEN_WIDTH:  sw_reg   <= cfg_data;
                tcld_pkg::REG_SCREEN_HEIGHT: sh_reg   <= cfg_data;
                tcld_pkg::REG_GLYPH_HEIGHT:  gh_reg   <= cfg_data[7:0];
                tcld_pkg::REG_MONO_WIDTH:    mw_reg   <= cfg_data[7:0];
                tcld_pkg::REG_PROPORTIONAL:  prop_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Acceptance. The block takes an item only from the idle state, so a
    // table write and a later read of the same entry never overlap in the
    // RAM: the write lands at the accept edge of the load item, and a read
    // is issued no earlier than the accept edge of a later item.
    // ------------------------------------------------------------------
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    assign stop      = STOP_W'(mw_reg) * STOP_W'(TAB_GLYPHS);
    assign stop_zero = (stop == '0);

    assign in_gi        = 7'(char_byte - tcld_pkg::CH_SPACE);
    assign in_printable = (char_byte >= tcld_pkg::CH_SPACE) && (char_byte <= tcld_pkg::CH_TILDE);
    assign in_gi_ok     = ({1'b0, in_gi} < 8'(GLYPH_COUNT));
    assign in_ti_ok     = ({1'b0, table_index} < 8'(GLYPH_COUNT));
    assign is_tab_in    = (kind == tcld_pkg::KIND_CHAR) && (char_byte == tcld_pkg::CH_TAB);

    // The width table lives in the RAM. A load writes at acceptance; a
    // printable character reads its width so that it is ready in COMMIT.
    assign ram_we   = accept && (kind == tcld_pkg::KIND_LOAD) && in_ti_ok;
    assign ram_en   = accept && (kind == tcld_pkg::KIND_CHAR) && in_printable && in_gi_ok;
    assign ram_addr = (kind == tcld_pkg::KIND_LOAD) ? table_index[AW-1:0] : in_gi[AW-1:0];

    tcld_ram #(
        .WIDTH (8),
        .DEPTH (GLYPH_COUNT)
    ) u_width_table (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (table_width),
        .rdata (ram_rdata)
    );

    // The tab stop needs the column modulo the stop width. The column and
    // the stop do not change while the unit runs, so it latches them at start.
    assign div_start = accept && is_tab_in && !stop_zero;

    tcld_rem #(
        .DW (12),
        .VW (STOP_W)
    ) u_tab_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (col_reg),
        .divisor   (stop),
        .stat      (div_stat),
        .remainder (div_rem)
    );

    // ------------------------------------------------------------------
    // Result computation, used in COMMIT.
    // ------------------------------------------------------------------

    // Line feed: down one glyph height unless that would leave the screen.
    assign lf_sum = {1'b0, row_reg} + 13'(gh_reg);
    assign lf_ok  = (lf_sum < {1'b0, sh_reg});
    assign lf_row = lf_ok ? lf_sum[11:0] : row_reg;

    // Printable glyph width: mono, or from the table; in proportional mode glyphs
    // past the table are zero wide.
    assign gi_c      = 7'(ch_reg - tcld_pkg::CH_SPACE);
    assign gi_ok_c   = ({1'b0, gi_c} < 8'(GLYPH_COUNT));
    assign gw_c      = prop_reg ? (gi_ok_c ? ram_rdata : 8'd0) : mw_reg;
    assign glyph_sum = {1'b0, col_reg} + 13'(gw_c);

    // Tab target: next stop, or the current column when the stop is zero.
    assign tab_target = stop_zero ? TGT_W'(col_reg)
                                  : TGT_W'(col_reg) + TGT_W'(stop) - TGT_W'(div_rem);
    assign tab_wrap   = (tab_target >= TGT_W'(sw_reg));
    assign tab_final  = tab_wrap ? (tab_target - TGT_W'(sw_reg)) : tab_target;

    assign glyph_col = (glyph_sum >= {1'b0, sw_reg}) ? 12'd0 : col_reg;

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        status_next = tcld_pkg::ST_CONTROL;
        dx_next     = '0;
        dy_next     = '0;
        gi_next     = '0;
        gw_next     = '0;
        scroll_next = 1'b0;
        if (kind_reg == tcld_pkg::KIND_LOAD)
        begin
            status_next = tcld_pkg::ST_LOADED;
        end
        else
        begin
            case (ch_reg)
                tcld_pkg::CH_LF:
                begin
                    col_next    = '0;
                    row_next    = lf_row;
                    scroll_next = !lf_ok;
                end
                tcld_pkg::CH_CR:
                begin
                    col_next = '0;
                end
                tcld_pkg::CH_TAB:
                begin
                    col_next = tab_final[11:0];
                    if (tab_wrap)
                    begin
                        row_next    = lf_row;
                        scroll_next = !lf_ok;
                    end
                end
                default:
                begin
                    if (ch_reg inside {[tcld_pkg::CH_SPACE:tcld_pkg::CH_TILDE]})
                    begin
                        // A glyph that would reach the right edge wraps first.
                        status_next = tcld_pkg::ST_GLYPH;
                        gi_next     = gi_c;
                        gw_next     = gw_c;
                        dx_next     = glyph_col;
                        if (glyph_sum >= {1'b0, sw_reg})
                        begin
                            row_next    = lf_row;
                            scroll_next = !lf_ok;
                            dy_next     = lf_row;
                        end
                        else
                        begin
                            dy_next = row_reg;
                        end
                        col_next = glyph_col + 12'(gw_c);
                    end
                    else
                    begin
                        status_next = tcld_pkg::ST_REJECTED;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    assign commit_go = (state_reg == S_COMMIT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = div_start ? S_DIVIDE : S_COMMIT;
                end
            end
            S_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (commit_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (commit_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit_go)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            ch_reg   <= char_byte;
        end
        if (commit_go)
        begin
            status_reg <= status_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            gi_reg     <= gi_next;
            gw_reg     <= gw_next;
            scroll_reg <= scroll_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign draw_x         = dx_reg;
    assign draw_y         = dy_reg;
    assign glyph_code     = gi_reg;
    assign glyph_width    = gw_reg;
    assign scroll_request = scroll_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The remainder unit only finishes while the sequencer waits for it.
    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIVIDE))
        else $error("remainder unit finished outside the divide state");

    // A finished remainder is always below the tab stop width.
    a_rem_below_stop: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (div_rem < stop))
        else $error("tab remainder not below the stop width");

    // The table RAM is never written and read in the same cycle.
    a_ram_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_en))
        else $error("width table written and read together");

    // A commit always presents a result and frees the input side.
    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit_go |=> (out_valid && (state_reg == S_IDLE)))
        else $error("commit did not produce a result");

endmodule
